// ----- hw/rtl/bounded_confidence_event_step_defines.svh -----
// Assertion macros for the bounded-confidence event step block.
// Used by the top level; expects clk and rst in scope.
`ifndef BOUNDED_CONFIDENCE_EVENT_STEP_DEFINES_SVH
`define BOUNDED_CONFIDENCE_EVENT_STEP_DEFINES_SVH

// condition holds in the same cycle
`define BCS_AST_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcs assertion failed");

// condition holds in the next cycle
`define BCS_AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcs assertion failed");

`endif

// ----- hw/rtl/bcs_pkg.sv -----
// Package for the bounded-confidence event step block.
// Types, opcodes, status and state codes and register indexes; no dependencies.
`timescale 1ns / 1ps
package bcs_pkg;

  localparam logic [1:0] OP_LOAD_OPINION = 2'd0;
  localparam logic [1:0] OP_LOAD_EDGE    = 2'd1;
  localparam logic [1:0] OP_STEP         = 2'd2;
  localparam logic [1:0] OP_READ_OPINION = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_QUEUE  = 2'd1;
  localparam logic [1:0] STATUS_HALTED = 2'd2;

  localparam logic [2:0] REG_CONF_BOUND = 3'd0;
  localparam logic [2:0] REG_TOLERANCE  = 3'd1;
  localparam logic [2:0] REG_GAIN       = 3'd2;
  localparam logic [2:0] REG_STABLE_RUN = 3'd3;
  localparam logic [2:0] REG_MIN_STEPS  = 3'd4;

  typedef struct packed {
    logic [15:0] confidence_bound;
    logic [15:0] tolerance;
    logic [15:0] gain;
  } bcs_cfg_t;

  typedef struct packed {
    logic        did;
    logic [15:0] y1;
    logic [15:0] y2;
  } bcs_upd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_HEAD_WAIT,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_EP_RD,
    ST_EP_WAIT,
    ST_OP1_WAIT,
    ST_OP2_WAIT,
    ST_UPD,
    ST_WR2,
    ST_RD_OP,
    ST_DONE
  } bcs_state_t;

endpackage

// ----- hw/rtl/bounded_confidence_event_step.sv -----
// Edge load inserts from the tail, shifting each of the k later-timed queue entries up one place;
// it may stop short of the head. Step reinserts the head entry, passing m entries; warm-up ends
// there, with interact it also reads the endpoints and both opinions and may update them (queue
// memory, one read per cycle). One item at a time; a held result stalls the input.
// Reset (rst, synchronous): counters, fill and halted clear; registers take their
// defaults; opinion, endpoint and queue memories stay undefined, no clearing pass.
`timescale 1ns / 1ps
module bounded_confidence_event_step
  import bcs_pkg::*;
#(
  parameter int NODES = 1024,
  parameter int EDGES = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,   // opcode
  // node_index, opinion_value, edge_index, source_node, target_node,
  // activation_time, time_increment, interact
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [1:0]   m_tuser,   // status
  // fired_edge, interacted, stabilized, step_count, fixed_run, read_value
  output logic [87:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

`include "bounded_confidence_event_step_defines.svh"

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int EW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int QW = EW + 32;
  localparam logic [EW:0] FILL_FULL = (EW + 1)'(EDGES);

  logic [9:0]  in_node;
  logic [15:0] in_opv;
  logic [11:0] in_edge;
  logic [9:0]  in_src;
  logic [9:0]  in_dst;
  logic [31:0] in_atime;
  logic [31:0] in_incr;
  logic        in_inter;

  assign in_node  = s_tdata[9:0];
  assign in_opv   = s_tdata[25:10];
  assign in_edge  = s_tdata[37:26];
  assign in_src   = s_tdata[47:38];
  assign in_dst   = s_tdata[57:48];
  assign in_atime = s_tdata[89:58];
  assign in_incr  = s_tdata[121:90];
  assign in_inter = s_tdata[122];

  logic [15:0] opinions [NODES];
  logic [2*NW-1:0] endpoints [EDGES];
  logic [QW-1:0] queue [EDGES];

  bcs_state_t state, state_next;
  bcs_cfg_t   cfg;
  logic [19:0] stable_run;
  logic [31:0] min_steps;

  logic [EW:0]   fill;
  logic [31:0]   not_fixed;
  logic [19:0]   fixed_cnt;
  logic [31:0]   steps;
  logic          halted;

  logic [EW-1:0] pos;
  logic [EW-1:0] cur_edge;
  logic [EW-1:0] fired;
  logic [31:0]   cur_time;
  logic [31:0]   incr;
  logic          inter;
  logic [NW-1:0] n1;
  logic [NW-1:0] n2;
  logic [15:0]   x1;
  logic [1:0]    status;
  logic          did;
  logic [15:0]   readv;

  logic [NW-1:0] op_raddr, op_waddr;
  logic [15:0]   op_wdata, op_rdata;
  logic          op_we;
  logic [EW-1:0] q_raddr, q_waddr;
  logic [QW-1:0] q_wdata, q_rdata;
  logic          q_we;
  logic [2*NW-1:0] ep_rdata;
  logic          ep_we;

  logic accept;
  logic node_ok, edge_ok, full;
  logic [EW:0] pos_inc;
  logic [32:0] tsum;
  logic [31:0] q_rtime;
  bcs_upd_t upd;
  logic [19:0] fixed_next;
  logic [31:0] nf_next;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign node_ok   = 32'(in_node) < NODES;
  assign edge_ok   = (32'(in_edge) < EDGES) && (32'(in_src) < NODES) && (32'(in_dst) < NODES);
  assign full      = (fill == FILL_FULL);
  assign pos_inc   = {1'b0, pos} + 1'b1;
  assign tsum      = {1'b0, q_rdata[QW-1:EW]} + {1'b0, incr};
  assign q_rtime   = q_rdata[QW-1:EW];

  always_ff @(posedge clk) begin
    if (op_we) opinions[op_waddr] <= op_wdata;
    op_rdata <= opinions[op_raddr];
  end

  always_ff @(posedge clk) begin
    if (ep_we) endpoints[EW'(in_edge)] <= {NW'(in_dst), NW'(in_src)};
    ep_rdata <= endpoints[cur_edge];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue[q_waddr] <= q_wdata;
    q_rdata <= queue[q_raddr];
  end

  bcs_update u_update (
    .clk (clk),
    .cfg (cfg),
    .x1  (x1),
    .x2  (op_rdata),
    .upd (upd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            OP_LOAD_EDGE:    state_next = (edge_ok && !full) ? ST_INS_RD : ST_DONE;
            OP_STEP:         state_next = (!halted && fill != '0) ? ST_HEAD_WAIT : ST_DONE;
            OP_READ_OPINION: state_next = node_ok ? ST_RD_OP : ST_DONE;
            default:         state_next = ST_DONE;
          endcase
        end
      end
      ST_INS_RD:    state_next = (pos == '0) ? ST_DONE : ST_INS_CMP;
      ST_INS_CMP:   state_next = (q_rtime > cur_time) ? ST_INS_RD : ST_DONE;
      ST_HEAD_WAIT: state_next = ST_SORT_RD;
      ST_SORT_RD:   state_next = (pos_inc < fill) ? ST_SORT_CMP : ST_EP_RD;
      ST_SORT_CMP:  state_next = (q_rtime <= cur_time) ? ST_SORT_RD : ST_EP_RD;
      ST_EP_RD:     state_next = inter ? ST_EP_WAIT : ST_DONE;
      ST_EP_WAIT:   state_next = ST_OP1_WAIT;
      ST_OP1_WAIT:  state_next = ST_OP2_WAIT;
      ST_OP2_WAIT:  state_next = ST_UPD;
      ST_UPD:       state_next = upd.did ? ST_WR2 : ST_DONE;
      ST_WR2:       state_next = ST_DONE;
      ST_RD_OP:     state_next = ST_DONE;
      ST_DONE:      state_next = (!m_tvalid || m_tready) ? ST_IDLE : ST_DONE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op_raddr = n2;
    op_waddr = NW'(in_node);
    op_wdata = in_opv;
    op_we    = 1'b0;
    q_raddr  = '0;
    q_waddr  = pos;
    q_wdata  = {cur_time, cur_edge};
    q_we     = 1'b0;
    ep_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        op_raddr = NW'(in_node);
        op_we    = accept && (s_tuser == OP_LOAD_OPINION) && node_ok;
        ep_we    = accept && (s_tuser == OP_LOAD_EDGE) && edge_ok && !full;
      end
      ST_INS_RD: begin
        q_raddr = pos - 1'b1;
        q_we    = (pos == '0);
      end
      ST_INS_CMP: begin
        q_we = 1'b1;
        if (q_rtime > cur_time) q_wdata = q_rdata;
      end
      ST_SORT_RD: begin
        q_raddr = pos_inc[EW-1:0];
        q_we    = !(pos_inc < fill);
      end
      ST_SORT_CMP: begin
        q_we = 1'b1;
        if (q_rtime <= cur_time) q_wdata = q_rdata;
      end
      ST_EP_WAIT:  op_raddr = ep_rdata[NW-1:0];
      ST_OP1_WAIT: op_raddr = n2;
      ST_UPD: begin
        op_we    = upd.did;
        op_waddr = n1;
        op_wdata = upd.y1;
      end
      ST_WR2: begin
        op_we    = 1'b1;
        op_waddr = n2;
        op_wdata = upd.y2;
      end
      default: ;
    endcase
  end

  always_comb begin
    fixed_next = fixed_cnt;
    nf_next    = not_fixed;
    if (upd.did) begin
      if (not_fixed != 32'hFFFF_FFFF) nf_next = not_fixed + 1'b1;
    end else if (not_fixed == '0) begin
      if (fixed_cnt != 20'hF_FFFF) fixed_next = fixed_cnt + 1'b1;
    end else begin
      fixed_next = 20'd1;
      nf_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      not_fixed <= '0;
      fixed_cnt <= '0;
      steps     <= '0;
      halted    <= 1'b0;
      m_tvalid  <= 1'b0;
      cfg.confidence_bound <= 16'd16384;
      cfg.tolerance        <= 16'd7;
      cfg.gain             <= 16'd32768;
      stable_run           <= 20'd500;
      min_steps            <= 32'd10000;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_CONF_BOUND: cfg.confidence_bound <= cfg_data[15:0];
          REG_TOLERANCE:  cfg.tolerance <= cfg_data[15:0];
          REG_GAIN:       cfg.gain <= cfg_data[15:0];
          REG_STABLE_RUN: stable_run <= cfg_data[19:0];
          REG_MIN_STEPS:  min_steps <= cfg_data;
          default: ;
        endcase
      end
      if ((state == ST_INS_RD && pos == '0) ||
          (state == ST_INS_CMP && !(q_rtime > cur_time)))
        fill <= fill + 1'b1;
      if (state == ST_UPD) begin
        not_fixed <= nf_next;
        fixed_cnt <= fixed_next;
        if (steps > min_steps && fixed_next == stable_run) halted <= 1'b1;
        if (steps != 32'hFFFF_FFFF) steps <= steps + 1'b1;
      end
      if (state == ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        status   <= STATUS_OK;
        did      <= 1'b0;
        readv    <= '0;
        cur_edge <= '0;
        fired    <= '0;
        cur_time <= in_atime;
        incr     <= in_incr;
        inter    <= in_inter;
        pos      <= fill[EW-1:0];
        if (accept) begin
          cur_edge <= EW'(in_edge);
          case (s_tuser)
            OP_LOAD_OPINION, OP_READ_OPINION: if (!node_ok) status <= STATUS_QUEUE;
            OP_LOAD_EDGE: if (!edge_ok || full) status <= STATUS_QUEUE;
            OP_STEP: begin
              if (halted) status <= STATUS_HALTED;
              else if (fill == '0) status <= STATUS_QUEUE;
            end
            default: ;
          endcase
        end
      end
      ST_INS_CMP: if (q_rtime > cur_time) pos <= pos - 1'b1;
      ST_HEAD_WAIT: begin
        cur_edge <= q_rdata[EW-1:0];
        fired    <= q_rdata[EW-1:0];
        cur_time <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
        pos      <= '0;
      end
      ST_SORT_CMP: if (q_rtime <= cur_time) pos <= pos_inc[EW-1:0];
      ST_EP_WAIT: begin
        n1 <= ep_rdata[NW-1:0];
        n2 <= ep_rdata[2*NW-1:NW];
      end
      ST_OP1_WAIT: x1 <= op_rdata;
      ST_UPD: did <= upd.did;
      ST_RD_OP: readv <= op_rdata;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tuser <= status;
          m_tdata <= {6'd0, readv, fixed_cnt, steps, halted, did,
                      12'(fired)};
        end
      end
      default: ;
    endcase
  end

  `BCS_AST_NOW(a_fill_bound, 1'b1, fill <= FILL_FULL)
  `BCS_AST_NEXT(a_halt_sticky, halted, halted)
  `BCS_AST_NOW(a_sort_in_queue, state == ST_SORT_CMP, pos_inc < fill)

endmodule

// ----- hw/rtl/bcs_update.sv -----
// Bounded-confidence opinion update with floor rounding, one register stage.
// Depends on bcs_pkg.
`timescale 1ns / 1ps
module bcs_update
  import bcs_pkg::*;
(
  input  logic        clk,
  input  bcs_cfg_t    cfg,
  input  logic [15:0] x1,
  input  logic [15:0] x2,
  output bcs_upd_t    upd
);

  logic signed [16:0] diff;
  logic signed [16:0] gain_s;
  logic signed [33:0] prod1;
  logic signed [33:0] prod2;
  logic        [17:0] y1_w;
  logic        [17:0] y2_w;
  logic        [16:0] gap;
  logic               near;

  always_comb begin
    diff   = $signed({1'b0, x2}) - $signed({1'b0, x1});
    gain_s = $signed({1'b0, cfg.gain});
    prod1  = diff * gain_s;
    prod2  = (-diff) * gain_s;
    gap    = diff[16] ? 17'(-diff) : 17'(diff);
    near   = (gap < {1'b0, cfg.confidence_bound}) && (gap > {1'b0, cfg.tolerance});
    y1_w   = {2'b00, x1} + 18'(prod1 >>> 16);
    y2_w   = {2'b00, x2} + 18'(prod2 >>> 16);
  end

  always_ff @(posedge clk) begin
    upd.did <= near;
    upd.y1  <= y1_w[15:0];
    upd.y2  <= y2_w[15:0];
  end

endmodule
